/* hw/rtl/uhei_pkg.sv */
`default_nettype none
package uhei_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [7:0] ChrDash  = 8'h2d;
  localparam logic [7:0] ChrUnder = 8'h5f;
  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [CodeW-1:0] CodeBad = 21'h00003f;
  localparam logic [CodeW-1:0] CodeLongMin = 21'h00ffff;

  typedef enum logic [1:0] {
    SEG_ESC_A,
    SEG_LIT,
    SEG_ESC_B
  } seg_t;

  // one input byte's worth of output work
  typedef struct packed {
    logic             esc_a_vld;
    logic [CodeW-1:0] esc_a_code;
    logic             lit_vld;
    logic [7:0]       lit_byte;
    logic             esc_b_vld;
    logic [CodeW-1:0] esc_b_code;
    logic             last;
  } job_t;

  function automatic logic [CodeW-1:0] resolve_code(
    input logic [CodeW-1:0] code,
    input logic [2:0]       bexp,
    input logic [2:0]       bseen,
    input logic             inv
  );
    logic bad;
    bad = inv || (bseen != bexp);
    if (bexp == 3'd2 && code < 21'h000080) bad = 1'b1;
    if (bexp == 3'd3 && code < 21'h000800) bad = 1'b1;
    if (bexp == 3'd4 && code < 21'h010000) bad = 1'b1;
    if (code >= 21'h00d800 && code <= 21'h00dfff) bad = 1'b1;
    if (code > 21'h10ffff) bad = 1'b1;
    return bad ? CodeBad : code;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
           (b >= 8'h61 && b <= 8'h7a);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/uhei_front.sv */
`default_nettype none
module uhei_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end_of_name,
  output uhei_pkg::job_t         job,
  output logic                   job_push
);

  logic                       space_r, space_nxt;
  logic                       pend_r, pend_nxt;
  logic [uhei_pkg::CodeW-1:0] acc_r, acc_nxt;
  logic [2:0]                 exp_r, exp_nxt;
  logic [2:0]                 seen_r, seen_nxt;
  logic                       inv_r, inv_nxt;

  // state after the byte, before the end-of-name flush
  logic                       s_space, s_pend, s_inv;
  logic [uhei_pkg::CodeW-1:0] s_acc;
  logic [2:0]                 s_exp, s_seen;
  logic                       cont;

  always_comb begin
    cont       = (in_byte[7:6] == 2'b10);
    s_space    = space_r;
    s_pend     = pend_r;
    s_acc      = acc_r;
    s_exp      = exp_r;
    s_seen     = seen_r;
    s_inv      = inv_r;
    job        = '0;
    job.last   = in_end_of_name;
    if (cont && pend_r) begin
      s_seen = (seen_r < 3'd7) ? seen_r + 3'd1 : seen_r;
      if (s_seen > exp_r) begin
        s_inv = 1'b1;
      end else begin
        s_acc = {acc_r[uhei_pkg::CodeW-7:0], in_byte[5:0]};
      end
    end else begin
      job.esc_a_vld  = pend_r;
      job.esc_a_code = uhei_pkg::resolve_code(acc_r, exp_r, seen_r, inv_r);
      s_pend = 1'b0;
      s_acc  = '0;
      s_exp  = '0;
      s_seen = '0;
      s_inv  = 1'b0;
      if (in_byte == uhei_pkg::ChrSpace) begin
        job.lit_vld  = !space_r;
        job.lit_byte = uhei_pkg::ChrDash;
        s_space      = 1'b1;
      end else begin
        s_space = 1'b0;
        if (uhei_pkg::is_alnum(in_byte)) begin
          job.lit_vld  = 1'b1;
          job.lit_byte = in_byte;
        end else begin
          s_pend = 1'b1;
          s_seen = 3'd1;
          if (in_byte < 8'h80) begin
            s_exp = 3'd1;
            s_acc = {13'd0, in_byte};
          end else if (in_byte >= 8'hc2 && in_byte <= 8'hdf) begin
            s_exp = 3'd2;
            s_acc = {16'd0, in_byte[4:0]};
          end else if (in_byte >= 8'he0 && in_byte <= 8'hef) begin
            s_exp = 3'd3;
            s_acc = {17'd0, in_byte[3:0]};
          end else if (in_byte >= 8'hf0 && in_byte <= 8'hf4) begin
            s_exp = 3'd4;
            s_acc = {18'd0, in_byte[2:0]};
          end else begin
            s_exp = 3'd1;
            s_inv = 1'b1;
          end
        end
      end
    end
    job.esc_b_vld  = in_end_of_name && s_pend;
    job.esc_b_code = uhei_pkg::resolve_code(s_acc, s_exp, s_seen, s_inv);
    job_push = accept && (job.esc_a_vld || job.lit_vld || job.esc_b_vld);
  end

  always_comb begin
    space_nxt = space_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    exp_nxt   = exp_r;
    seen_nxt  = seen_r;
    inv_nxt   = inv_r;
    if (accept) begin
      if (in_end_of_name) begin
        space_nxt = 1'b0;
        pend_nxt  = 1'b0;
        acc_nxt   = '0;
        exp_nxt   = '0;
        seen_nxt  = '0;
        inv_nxt   = 1'b0;
      end else begin
        space_nxt = s_space;
        pend_nxt  = s_pend;
        acc_nxt   = s_acc;
        exp_nxt   = s_exp;
        seen_nxt  = s_seen;
        inv_nxt   = s_inv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r <= 1'b0;
      pend_r  <= 1'b0;
      acc_r   <= '0;
      exp_r   <= '0;
      seen_r  <= '0;
      inv_r   <= 1'b0;
    end else begin
      space_r <= space_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
      exp_r   <= exp_nxt;
      seen_r  <= seen_nxt;
      inv_r   <= inv_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/uhei_fifo.sv */
`default_nettype none
module uhei_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire uhei_pkg::job_t wr_data,
  input  wire logic           rd_en,
  output uhei_pkg::job_t      rd_data,
  output logic                full,
  output logic                not_empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  uhei_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [AW-1:0]  rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/uhei_back.sv */
`default_nettype none
module uhei_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire uhei_pkg::job_t job,
  input  wire logic           job_vld,
  output logic                job_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_name_done
);

  uhei_pkg::seg_t phase_r, phase_nxt;
  uhei_pkg::seg_t seg_eff;
  logic [2:0]     idx_r, idx_nxt;
  logic           vld_r, vld_nxt;
  logic [7:0]     byte_r;
  logic           run_last_r, name_done_r;

  logic [uhei_pkg::CodeW-1:0] code;
  logic                       long_form;
  logic [2:0]                 len_m1, pos;
  logic [3:0]                 nib;
  logic [7:0]                 chr;
  logic                       seg_end, later, job_done, step;

  always_comb begin
    if (phase_r == uhei_pkg::SEG_ESC_A && job.esc_a_vld) begin
      seg_eff = uhei_pkg::SEG_ESC_A;
    end else if (phase_r != uhei_pkg::SEG_ESC_B && job.lit_vld) begin
      seg_eff = uhei_pkg::SEG_LIT;
    end else begin
      seg_eff = uhei_pkg::SEG_ESC_B;
    end
  end

  // character generation for the current segment
  always_comb begin
    code      = (seg_eff == uhei_pkg::SEG_ESC_A) ? job.esc_a_code : job.esc_b_code;
    long_form = (code >= uhei_pkg::CodeLongMin);
    len_m1    = long_form ? 3'd7 : 3'd4;
    pos       = len_m1 - idx_r;
    case (pos)
      3'd0:    nib = code[3:0];
      3'd1:    nib = code[7:4];
      3'd2:    nib = code[11:8];
      3'd3:    nib = code[15:12];
      3'd4:    nib = code[19:16];
      3'd5:    nib = {3'd0, code[20]};
      default: nib = 4'd0;
    endcase
    if (seg_eff == uhei_pkg::SEG_LIT) begin
      chr = job.lit_byte;
    end else if (idx_r == 3'd0 || (long_form && idx_r == 3'd1)) begin
      chr = uhei_pkg::ChrUnder;
    end else begin
      chr = uhei_pkg::hex_char(nib);
    end
  end

  // sequencer outputs
  always_comb begin
    unique case (seg_eff)
      uhei_pkg::SEG_ESC_A: begin
        seg_end = (idx_r == len_m1);
        later   = job.lit_vld || job.esc_b_vld;
      end
      uhei_pkg::SEG_LIT: begin
        seg_end = 1'b1;
        later   = job.esc_b_vld;
      end
      default: begin
        seg_end = (idx_r == len_m1);
        later   = 1'b0;
      end
    endcase
    job_done = seg_end && !later;
    step     = job_vld && (!vld_r || pop);
    job_pop  = step && job_done;
  end

  // sequencer next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (step) begin
      if (seg_end) begin
        idx_nxt = '0;
        if (job_done) begin
          phase_nxt = uhei_pkg::SEG_ESC_A;
        end else begin
          unique case (seg_eff)
            uhei_pkg::SEG_ESC_A: phase_nxt = uhei_pkg::SEG_LIT;
            default:             phase_nxt = uhei_pkg::SEG_ESC_B;
          endcase
        end
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
    if (step) begin
      vld_nxt = 1'b1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uhei_pkg::SEG_ESC_A;
      idx_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r      <= chr;
      run_last_r  <= job_done;
      name_done_r <= job_done && job.last;
    end
  end

  assign empty         = !vld_r;
  assign out_byte      = byte_r;
  assign out_run_last  = run_last_r;
  assign out_name_done = name_done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && name_done_r |-> run_last_r)
    else $error("name_done without run_last");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (phase_r == uhei_pkg::SEG_ESC_A) && (idx_r == 3'd0))
    else $error("sequencer not rewound after job");

  a_lit_single: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld && seg_eff == uhei_pkg::SEG_LIT |-> idx_r == 3'd0)
    else $error("literal segment with nonzero index");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld |-> idx_r <= len_m1)
    else $error("escape index past its length");

endmodule
`default_nettype wire

/* hw/rtl/utf8_hex_escape_identifier.sv */
// A result is written into the job queue and then into the output register; an escape
// held for the next byte enters the queue with that byte (or with the end of the name).
// Throughput: one input byte per cycle while full is low; the output side writes one
// character per cycle while pop keeps up, so an escape holds the back end longer.
// The job queue of QUEUE_DEPTH entries absorbs the difference before full rises.
// Reset (rst_n low, synchronous) clears the decoder state and empties the queue and the output register.
`default_nettype none
module utf8_hex_escape_identifier #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_name,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_name_done
);

  uhei_pkg::job_t front_job, head_job;
  logic           front_push, head_vld, head_pop, accept;

  assign accept = push && !full;

  uhei_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_name (in_end_of_name),
    .job            (front_job),
    .job_push       (front_push)
  );

  uhei_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (front_push),
    .wr_data   (front_job),
    .rd_en     (head_pop),
    .rd_data   (head_job),
    .full      (full),
    .not_empty (head_vld)
  );

  uhei_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (head_job),
    .job_vld       (head_vld),
    .job_pop       (head_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_name_done (out_name_done)
  );

endmodule
`default_nettype wire
